// File: sv/spim_pkg.sv
package spim_pkg;

  localparam int NUM_SLAVES_DEF = 8;
  localparam int SEL_W          = 8;
  localparam int BYTE_W         = 8;
  localparam int IDX_W          = 3;
  localparam int MODE_W         = 2;
  localparam int EDGE_W         = 4;
  localparam logic [EDGE_W-1:0] LAST_EDGE = 4'd15;
  localparam int CMDQ_DEPTH     = 2;

  typedef enum logic [1:0] {
    MODE_SELECT   = 2'd0,
    MODE_DESELECT = 2'd1,
    MODE_LOAD     = 2'd2,
    MODE_TICK     = 2'd3
  } in_mode_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_SELECT,
    CMD_DESELECT,
    CMD_LOAD,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  slave_index;
    logic [BYTE_W-1:0] send_byte;
    logic              miso_level;
  } cmd_t;

  typedef struct packed {
    logic              clock_level;
    logic              mosi_level;
    logic [SEL_W-1:0]  select_lines;
    logic [BYTE_W-1:0] received_byte;
    logic              busy_res;
    logic              byte_done;
  } result_t;

endpackage

// File: sv/spim_front.sv
module spim_front
  import spim_pkg::*;
#(
  parameter int NUM_SLAVES = NUM_SLAVES_DEF
) (
  input  logic [MODE_W-1:0] in_mode,
  input  logic [IDX_W-1:0]  in_slave_index,
  input  logic [BYTE_W-1:0] in_send_byte,
  input  logic              in_miso_level,
  output cmd_t              cmd
);

  localparam logic [IDX_W:0] NUM_SLAVES_L = (IDX_W+1)'(NUM_SLAVES);

  logic idx_ok;

  assign idx_ok = {1'b0, in_slave_index} < NUM_SLAVES_L;

  always_comb begin
    cmd.slave_index = in_slave_index;
    cmd.send_byte   = in_send_byte;
    cmd.miso_level  = in_miso_level;
    case (in_mode_t'(in_mode))
      MODE_SELECT:   cmd.kind = idx_ok ? CMD_SELECT : CMD_NOP;
      MODE_DESELECT: cmd.kind = idx_ok ? CMD_DESELECT : CMD_NOP;
      MODE_LOAD:     cmd.kind = CMD_LOAD;
      MODE_TICK:     cmd.kind = CMD_TICK;
      default:       cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// File: sv/spim_queue.sv
module spim_queue
  import spim_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMDQ_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMDQ_DEPTH);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = cnt_r == CNT_FULL;
  assign valid    = cnt_r != '0;
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/spim_back.sv
module spim_back
  import spim_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output result_t           res
);

  logic [1:0]        clock_mode_r, clock_mode_nxt;
  logic              sck_r, sck_nxt;
  logic              mosi_r, mosi_nxt;
  logic [BYTE_W-1:0] tx_r, tx_nxt;
  logic [BYTE_W-1:0] rx_r, rx_nxt;
  logic [EDGE_W-1:0] edge_r, edge_nxt;
  logic              active_r, active_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           res_r, res_nxt;
  logic              take, done, leading, sample_now, cpol, cpha;
  logic [SEL_W-1:0]  idx_mask;

  assign cpol      = clock_mode_r[1];
  assign cpha      = clock_mode_r[0];
  assign take      = q_valid & (~out_valid_r | out_pop);
  assign q_pop     = take;
  assign out_empty = ~out_valid_r;
  assign res       = res_r;
  assign leading   = ~edge_r[0];
  assign sample_now = cpha ? ~leading : leading;
  assign idx_mask  = SEL_W'(1) << q_cmd.slave_index;

  always_comb begin
    clock_mode_nxt = clock_mode_r;
    sck_nxt        = sck_r;
    mosi_nxt       = mosi_r;
    tx_nxt         = tx_r;
    rx_nxt         = rx_r;
    edge_nxt       = edge_r;
    active_nxt     = active_r;
    sel_nxt        = sel_r;
    done           = 1'b0;

    if (take) begin
      case (q_cmd.kind)
        CMD_SELECT:   sel_nxt = sel_r & ~idx_mask;
        CMD_DESELECT: sel_nxt = sel_r | idx_mask;
        CMD_LOAD: begin
          if (!active_r) begin
            active_nxt = 1'b1;
            edge_nxt   = '0;
            rx_nxt     = '0;
            sck_nxt    = cpol;
            if (!cpha) begin
              mosi_nxt = q_cmd.send_byte[BYTE_W-1];
              tx_nxt   = {q_cmd.send_byte[BYTE_W-2:0], 1'b0};
            end else begin
              tx_nxt = q_cmd.send_byte;
            end
          end
        end
        CMD_TICK: begin
          if (active_r) begin
            sck_nxt = leading ? ~cpol : cpol;
            if (sample_now) begin
              rx_nxt = {rx_r[BYTE_W-2:0], q_cmd.miso_level};
            end else if (edge_r != LAST_EDGE) begin
              mosi_nxt = tx_r[BYTE_W-1];
              tx_nxt   = {tx_r[BYTE_W-2:0], 1'b0};
            end
            edge_nxt = edge_r + 1'b1;
            if (edge_r == LAST_EDGE) begin
              active_nxt = 1'b0;
              done       = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (cfg_wr_en) begin
      clock_mode_nxt = cfg_wr_data;
      if (!active_r) begin
        sck_nxt = cfg_wr_data[1];
      end
    end

    res_nxt.clock_level   = sck_nxt;
    res_nxt.mosi_level    = mosi_nxt;
    res_nxt.select_lines  = sel_nxt;
    res_nxt.received_byte = rx_nxt;
    res_nxt.busy_res      = active_nxt;
    res_nxt.byte_done     = done;

    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_mode_r <= '0;
      sck_r        <= 1'b0;
      mosi_r       <= 1'b0;
      tx_r         <= '0;
      rx_r         <= '0;
      edge_r       <= '0;
      active_r     <= 1'b0;
      sel_r        <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      clock_mode_r <= clock_mode_nxt;
      sck_r        <= sck_nxt;
      mosi_r       <= mosi_nxt;
      tx_r         <= tx_nxt;
      rx_r         <= rx_nxt;
      edge_r       <= edge_nxt;
      active_r     <= active_nxt;
      sel_r        <= sel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: sv/spi_master_byte_shifter_core.sv
// SPI master byte shifter, clock modes 0 to 3, MSB first. Each beat on the
// input queue selects or deselects a slave, loads a byte, or is one SCK half
// period carrying the sampled MISO level; each beat yields exactly one result
// beat with the pin levels after it. Sixteen ticks finish a byte and raise
// byte_done. Throughput is one beat per clock, in and out, with pop and push
// in the same cycle, while out_pop keeps taking results; a result passes
// through the two-entry command queue and then the result register. Write cfg only
// while no beat is in flight.
module spi_master_byte_shifter_core
  import spim_pkg::*;
#(
  parameter int NUM_SLAVES = NUM_SLAVES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic              in_push,
  output logic              in_full,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [IDX_W-1:0]  in_slave_index,
  input  logic [BYTE_W-1:0] in_send_byte,
  input  logic              in_miso_level,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_clock_level,
  output logic              out_mosi_level,
  output logic [SEL_W-1:0]  out_select_lines,
  output logic [BYTE_W-1:0] out_received_byte,
  output logic              out_busy_res,
  output logic              out_byte_done
);

  cmd_t    front_cmd, head_cmd;
  logic    q_valid, q_pop;
  result_t res;

  spim_front #(
    .NUM_SLAVES(NUM_SLAVES)
  ) u_front (
    .in_mode        (in_mode),
    .in_slave_index (in_slave_index),
    .in_send_byte   (in_send_byte),
    .in_miso_level  (in_miso_level),
    .cmd            (front_cmd)
  );

  spim_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_cmd (front_cmd),
    .full     (in_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (head_cmd)
  );

  spim_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .res         (res)
  );

  assign out_clock_level   = res.clock_level;
  assign out_mosi_level    = res.mosi_level;
  assign out_select_lines  = res.select_lines;
  assign out_received_byte = res.received_byte;
  assign out_busy_res      = res.busy_res;
  assign out_byte_done     = res.byte_done;

endmodule

// File: sv/spim_checker.sv
module spim_checker
  import spim_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic [SEL_W-1:0]  out_select_lines,
  input logic [BYTE_W-1:0] out_received_byte,
  input logic              out_busy_res,
  input logic              out_byte_done
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_byte_done) |-> !out_busy_res)
    else $error("byte_done beat still shows busy");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_received_byte) && $stable(out_select_lines)))
    else $error("stalled result beat changed");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full after reset");

endmodule

bind spi_master_byte_shifter_core spim_checker u_spim_checker (.*);

// File: dv/spi_master_byte_shifter_core_tb.sv
`timescale 1ns / 100ps

module spi_master_byte_shifter_core_tb
  import spim_pkg::*;
();

  localparam int HALF_CLOCKS = 16;
  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD = 400;

  class spi_pin_predictor;
    logic [1:0] clk_mode;
    logic sck;
    logic mosi;
    logic busy;
    logic [BYTE_W-1:0] tx_bits;
    logic [BYTE_W-1:0] rx_bits;
    logic [SEL_W-1:0] sel_n;
    logic [4:0] half_cnt;
    result_t exp_pins[$];
    int mismatches;

    function new();
      clk_mode = '0;
      sck = 1'b0;
      mosi = 1'b0;
      busy = 1'b0;
      tx_bits = '0;
      rx_bits = '0;
      sel_n = '1;
      half_cnt = '0;
      mismatches = 0;
    endfunction

    function void write_mode(logic [1:0] v);
      clk_mode = v;
      if (!busy) sck = v[1];
    endfunction

    function void note_beat(in_mode_t m, logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] b,
                            logic miso);
      result_t r;
      logic done;
      logic lead;
      logic smp;
      done = 1'b0;
      case (m)
        MODE_SELECT: begin
          if (idx < NUM_SLAVES_DEF) sel_n[idx] = 1'b0;
        end
        MODE_DESELECT: begin
          if (idx < NUM_SLAVES_DEF) sel_n[idx] = 1'b1;
        end
        MODE_LOAD: begin
          if (!busy) begin
            busy = 1'b1;
            half_cnt = '0;
            rx_bits = '0;
            sck = clk_mode[1];
            if (!clk_mode[0]) begin
              mosi = b[7];
              tx_bits = b << 1;
            end else begin
              tx_bits = b;
            end
          end
        end
        default: begin
          if (busy) begin
            lead = !half_cnt[0];
            smp = clk_mode[0] ? !lead : lead;
            sck = lead ? !clk_mode[1] : clk_mode[1];
            if (smp) begin
              rx_bits = {rx_bits[BYTE_W-2:0], miso};
            end else if (half_cnt + 1 < HALF_CLOCKS) begin
              mosi = tx_bits[7];
              tx_bits = tx_bits << 1;
            end
            half_cnt = half_cnt + 5'd1;
            if (half_cnt >= HALF_CLOCKS) begin
              half_cnt = '0;
              busy = 1'b0;
              done = 1'b1;
            end
          end
        end
      endcase
      r.clock_level = sck;
      r.mosi_level = mosi;
      r.select_lines = sel_n;
      r.received_byte = rx_bits;
      r.busy_res = busy;
      r.byte_done = done;
      exp_pins.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (exp_pins.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
        return;
      end
      want = exp_pins.pop_front();
      compare_field("clock_level", want.clock_level, got.clock_level);
      compare_field("mosi_level", want.mosi_level, got.mosi_level);
      compare_field("select_lines", want.select_lines, got.select_lines);
      compare_field("received_byte", want.received_byte, got.received_byte);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("byte_done", want.byte_done, got.byte_done);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [MODE_W-1:0] in_mode = MODE_SELECT;
  logic [IDX_W-1:0] in_slave_index = '0;
  logic [BYTE_W-1:0] in_send_byte = '0;
  logic in_miso_level = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_clock_level;
  logic out_mosi_level;
  logic [SEL_W-1:0] out_select_lines;
  logic [BYTE_W-1:0] out_received_byte;
  logic out_busy_res;
  logic out_byte_done;

  spi_pin_predictor pins = new();
  int beats_sent = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int unsigned cycle_count = 0;

  spi_master_byte_shifter_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_push(in_push),
    .in_full(in_full),
    .in_mode(in_mode),
    .in_slave_index(in_slave_index),
    .in_send_byte(in_send_byte),
    .in_miso_level(in_miso_level),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_clock_level(out_clock_level),
    .out_mosi_level(out_mosi_level),
    .out_select_lines(out_select_lines),
    .out_received_byte(out_received_byte),
    .out_busy_res(out_busy_res),
    .out_byte_done(out_byte_done)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_beat(in_mode_t m, logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] b,
                           logic miso);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_mode <= m;
    in_slave_index <= idx;
    in_send_byte <= b;
    in_miso_level <= miso;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pins.note_beat(m, idx, b, miso);
    beats_sent++;
  endtask

  task automatic push_noise();
    push_beat(in_mode_t'($urandom_range(0, 3)), IDX_W'($urandom), BYTE_W'($urandom),
              1'($urandom));
  endtask

  task automatic send_transfer();
    logic [IDX_W-1:0] s;
    int n;
    s = IDX_W'($urandom_range(0, NUM_SLAVES_DEF - 1));
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, HALF_CLOCKS - 1) : HALF_CLOCKS;
    push_beat(MODE_SELECT, s, BYTE_W'($urandom), 1'($urandom));
    push_beat(MODE_LOAD, IDX_W'($urandom), BYTE_W'($urandom), 1'($urandom));
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) push_noise();
      push_beat(MODE_TICK, IDX_W'($urandom), BYTE_W'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 1) == 1) begin
      push_beat(MODE_DESELECT, s, BYTE_W'($urandom), 1'($urandom));
    end
  endtask

  task automatic set_clock_mode(logic [1:0] v);
    in_push <= 1'b0;
    while (pins.exp_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    pins.write_mode(v);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int stall;
    result_t got;
    stall = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        got.clock_level = out_clock_level;
        got.mosi_level = out_mosi_level;
        got.select_lines = out_select_lines;
        got.received_byte = out_received_byte;
        got.busy_res = out_busy_res;
        got.byte_done = out_byte_done;
        pins.check_beat(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else begin
        stall = idle_len();
        out_pop <= (stall == 0);
      end
    end
  end

  initial begin
    logic [1:0] phase_modes[4];
    int target;
    phase_modes = '{2'd3, 2'd1, 2'd2, 2'd0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick while idle, load with nobody selected, load while busy,
    // select and deselect in the middle of a byte
    push_beat(MODE_TICK, 3'd7, 8'hFF, 1'b1);
    push_beat(MODE_LOAD, 3'd0, 8'hFF, 1'b0);
    push_beat(MODE_SELECT, 3'd0, 8'h00, 1'b0);
    push_beat(MODE_LOAD, 3'd7, 8'h00, 1'b1);
    push_beat(MODE_SELECT, 3'd7, 8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) push_beat(MODE_TICK, 3'(i), 8'h5A, 1'(i >> 1));
    push_beat(MODE_DESELECT, 3'd7, 8'h00, 1'b0);
    for (int i = 0; i < 8; i++) push_beat(MODE_TICK, 3'(i), 8'hA5, 1'(~(i >> 1)));
    push_beat(MODE_TICK, 3'd0, 8'h00, 1'b0);
    push_beat(MODE_DESELECT, 3'd0, 8'hFF, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      set_clock_mode(ph < 4 ? phase_modes[ph] : 2'($urandom_range(0, 3)));
      no_idle = (ph % 4 == 3);
      if (ph == 2) hold_req = 1'b1;
      target = beats_sent + 85;
      while (beats_sent < target) begin
        if ($urandom_range(0, 5) == 0) push_noise();
        else send_transfer();
      end
    end
    in_push <= 1'b0;

    while (pins.exp_pins.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pins.mismatches == 0 && pins.exp_pins.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
